// ===== rtl/core/slit_pkg.sv =====
// slit_pkg: shared types and codes for the sorted insertion table.
// Used by the channel interfaces, the storage cell and the top level.
`default_nettype none

package slit_pkg;

    localparam int VAL_W   = 32;
    localparam int CNT_F_W = 6;

    // action codes
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_READ   = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic                    ins;
        logic                    rot;
        logic signed [VAL_W-1:0] new_val;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== rtl/core/slit_if.sv =====
// slit_in_if / slit_out_if: valid/ready channels of the sorted insertion table.
// Depends on slit_pkg for field widths.
`default_nettype none

interface slit_in_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       action;
    logic signed [slit_pkg::VAL_W-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface slit_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [slit_pkg::VAL_W-1:0]  value_out;
    logic [slit_pkg::CNT_F_W-1:0]       entry_count;
    logic [1:0]                         status;
    logic                               last;

    modport source (output valid, output value_out, output entry_count,
                    output status, output last, input ready);
    modport sink   (input valid, input value_out, input entry_count,
                    input status, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/slit_cell.sv =====
// slit_cell: one slot of the sorted chain; compares against the new value,
// shifts from its left neighbor on insert, rotates from its right on read out.
// Depends on slit_pkg.
`default_nettype none

module slit_cell #(
    parameter int DEPTH = 32,
    parameter int IDX   = 0
) (
    input  wire logic                               i_clk,
    input  wire slit_pkg::t_cell_ctl                i_ctl,
    input  wire logic [$clog2(DEPTH+1)-1:0]         i_count,
    input  wire logic                               i_prev_ge,
    input  wire logic signed [slit_pkg::VAL_W-1:0]  i_prev_val,
    input  wire logic signed [slit_pkg::VAL_W-1:0]  i_next_val,
    input  wire logic signed [slit_pkg::VAL_W-1:0]  i_head_val,
    output logic                                    o_ge,
    output logic signed [slit_pkg::VAL_W-1:0]       o_val
);

    localparam int CW = $clog2(DEPTH+1);
    localparam logic [CW-1:0] IDX_C  = CW'(IDX);
    localparam logic [CW-1:0] IDX_P1 = CW'(IDX + 1);

    logic signed [slit_pkg::VAL_W-1:0] r_val;
    logic signed [slit_pkg::VAL_W-1:0] n_val;
    logic                              valid;
    logic                              tail;

    assign valid = IDX_C < i_count;
    assign tail  = IDX_P1 == i_count;
    assign o_ge  = valid && (r_val >= i_ctl.new_val);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.ins) begin
            // first slot at or above the new value, or else the first empty slot, takes it; the rest shift up
            if (i_prev_ge) begin
                n_val = i_prev_val;
            end else if (o_ge || !valid) begin
                n_val = i_ctl.new_val;
            end
        end else if (i_ctl.rot && valid) begin
            n_val = tail ? i_head_val : i_next_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

`default_nettype wire

// ===== rtl/core/sorted_list_insert_table.sv =====
// sorted_list_insert_table: sorted table of signed 32-bit values on a cell chain.
// Depends on slit_pkg, slit_in_if / slit_out_if and slit_cell.
//
// Usage:
//   i_in carries one beat per command: action (insert, read out, clear) and
//   value. o_out carries result beats: value_out, entry_count, status, last.
//   Insert: every cell compares its entry with the new value in parallel and
//   the chain shifts up by one past the insert point; one
//   result beat (status full and no change when the table holds DEPTH values).
//   Read out: while the output is free the chain rotates one place per cycle
//   and cell 0 drives the output, so count entries leave and the table ends
//   where it started; an empty table gives one beat with the empty status.
//   Clear: count goes to zero, one result beat.
//   An insert, clear, unused code or empty read out shows its result beat the
//   cycle after the command beat; a read out first enters the read state and
//   then registers its first value beat, the rest follow one per free cycle.
//   Insert and clear take one command per cycle while the output is free; a
//   read out holds the input until its last beat is registered and taken.
//   A stalled receiver holds the output register and the input stays blocked
//   while that register is full and not being taken.
//   Reset empties the table; stored words are not cleared, only the count.
`default_nettype none

module sorted_list_insert_table #(
    parameter int DEPTH = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    slit_in_if.sink    i_in,
    slit_out_if.source o_out
);

    localparam int CW = $clog2(DEPTH+1);
    localparam logic [CW-1:0] FULL_C = CW'(DEPTH);

    slit_pkg::t_state    r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_rd_left, n_rd_left;
    logic                r_ov, n_ov;
    logic signed [slit_pkg::VAL_W-1:0] r_oval, n_oval;
    logic [CW-1:0]       r_ocnt, n_ocnt;
    logic [1:0]          r_ost, n_ost;
    logic                r_olast, n_olast;
    logic                emit;

    slit_pkg::t_cell_ctl ctl;
    logic                        cell_ge  [DEPTH];
    logic signed [slit_pkg::VAL_W-1:0] cell_val [DEPTH];

    logic          acc;
    logic          out_take;
    logic          slot_free;
    logic          full;
    logic [CW+slit_pkg::CNT_F_W-1:0] cnt_wide;

    assign out_take  = r_ov && o_out.ready;
    assign slot_free = !r_ov || out_take;
    assign full      = r_count == FULL_C;
    assign i_in.ready = (r_state == slit_pkg::S_IDLE) && slot_free;
    assign acc       = i_in.valid && i_in.ready;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            slit_cell #(
                .DEPTH (DEPTH),
                .IDX   (g)
            ) u_cell (
                .i_clk      (i_clk),
                .i_ctl      (ctl),
                .i_count    (r_count),
                .i_prev_ge  ((g == 0) ? 1'b0 : cell_ge[(g == 0) ? 0 : g-1]),
                .i_prev_val (cell_val[(g == 0) ? 0 : g-1]),
                .i_next_val (cell_val[(g + 1) % DEPTH]),
                .i_head_val (cell_val[0]),
                .o_ge       (cell_ge[g]),
                .o_val      (cell_val[g])
            );
        end
    endgenerate

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rd_left   = r_rd_left;
        n_ov        = out_take ? 1'b0 : r_ov;
        n_oval      = r_oval;
        n_ocnt      = r_ocnt;
        n_ost       = r_ost;
        n_olast     = r_olast;
        emit        = 1'b0;
        ctl.ins     = 1'b0;
        ctl.rot     = 1'b0;
        ctl.new_val = i_in.value;

        unique case (r_state)
            slit_pkg::S_IDLE: begin
                if (acc) begin
                    n_oval  = '0;
                    n_ocnt  = r_count;
                    n_ost   = slit_pkg::ST_OK;
                    n_olast = 1'b1;
                    emit    = 1'b1;
                    case (i_in.action)
                        slit_pkg::ACT_INSERT: begin
                            if (full) begin
                                n_ost = slit_pkg::ST_FULL;
                            end else begin
                                ctl.ins = 1'b1;
                                n_count = r_count + CW'(1);
                                n_ocnt  = r_count + CW'(1);
                            end
                        end
                        slit_pkg::ACT_READ: begin
                            if (r_count == '0) begin
                                n_ost = slit_pkg::ST_EMPTY;
                            end else begin
                                emit      = 1'b0;
                                n_state   = slit_pkg::S_READ;
                                n_rd_left = r_count;
                            end
                        end
                        slit_pkg::ACT_CLEAR: begin
                            n_count = '0;
                            n_ocnt  = '0;
                        end
                        default: ;
                    endcase
                end
            end
            slit_pkg::S_READ: begin
                if (slot_free) begin
                    emit      = 1'b1;
                    ctl.rot   = 1'b1;
                    n_oval    = cell_val[0];
                    n_ocnt    = r_count;
                    n_ost     = slit_pkg::ST_OK;
                    n_olast   = r_rd_left == CW'(1);
                    n_rd_left = r_rd_left - CW'(1);
                    if (r_rd_left == CW'(1)) begin
                        n_state = slit_pkg::S_IDLE;
                    end
                end
            end
            default: n_state = slit_pkg::S_IDLE;
        endcase

        if (emit) begin
            n_ov = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= slit_pkg::S_IDLE;
            r_count   <= '0;
            r_rd_left <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_rd_left <= n_rd_left;
            r_ov      <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_oval  <= n_oval;
        r_ocnt  <= n_ocnt;
        r_ost   <= n_ost;
        r_olast <= n_olast;
    end

    // entry_count field is 6 bits wide whatever the count width
    assign cnt_wide          = {{slit_pkg::CNT_F_W{1'b0}}, r_ocnt};
    assign o_out.valid       = r_ov;
    assign o_out.value_out   = r_oval;
    assign o_out.entry_count = cnt_wide[slit_pkg::CNT_F_W-1:0];
    assign o_out.status      = r_ost;
    assign o_out.last        = r_olast;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_C)
        else $error("stored count beyond depth");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_in.action == slit_pkg::ACT_INSERT && !full)
        |=> r_count == $past(r_count) + CW'(1))
        else $error("insert did not grow the count");

    a_read_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == slit_pkg::S_READ) |-> (r_rd_left != '0 && r_rd_left <= r_count))
        else $error("read out counter out of range");

    a_read_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == slit_pkg::S_READ && slot_free && r_rd_left == CW'(1))
        |=> (r_state == slit_pkg::S_IDLE && r_ov && r_olast))
        else $error("read out did not finish with a last beat");

endmodule

`default_nettype wire
